// ----- rtl/assert_macros.svh -----
// Assertion macros used by the estimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define LCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define LCE_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/lce_pkg.sv -----
// Types and constants of the line compressibility estimator.
`default_nettype none

package lce_pkg;

    localparam int LINE_WORDS = 8;
    localparam int WORD_BYTES = 8;

    typedef logic [63:0]        word_t;
    typedef logic signed [3:0]  flits_t;
    typedef logic [2:0]         delta_t;
    typedef logic [3:0]         byte_cnt_t;
    typedef logic [6:0]         line_cnt_t;

    // Policy register codes; the spare code behaves like POLICY_BOTH
    typedef enum logic [1:0] {
        POLICY_DELTA = 2'd0,
        POLICY_ZERO  = 2'd1,
        POLICY_BOTH  = 2'd2
    } policy_t;

endpackage

`default_nettype wire

// ----- rtl/lce_if.sv -----
// Valid/ready channel interfaces for cache lines and estimates.
`default_nettype none

interface lce_line_if;
    logic           valid;
    logic           ready;
    lce_pkg::word_t word0;
    lce_pkg::word_t word1;
    lce_pkg::word_t word2;
    lce_pkg::word_t word3;
    lce_pkg::word_t word4;
    lce_pkg::word_t word5;
    lce_pkg::word_t word6;
    lce_pkg::word_t word7;

    modport source (
        output valid, word0, word1, word2, word3, word4, word5, word6, word7,
        input  ready
    );
    modport sink (
        input  valid, word0, word1, word2, word3, word4, word5, word6, word7,
        output ready
    );
endinterface

interface lce_est_if;
    logic            valid;
    logic            ready;
    lce_pkg::flits_t flits_saved;
    logic            chose_zero;
    lce_pkg::delta_t delta_saved;
    lce_pkg::flits_t zero_saved;

    modport source (
        output valid, flits_saved, chose_zero, delta_saved, zero_saved,
        input  ready
    );
    modport sink (
        input  valid, flits_saved, chose_zero, delta_saved, zero_saved,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/line_compressibility_estimator.sv -----
// Top level: three-stage pipelined delta / zero-content compression estimator.
//
//  channel    dir  handshake           payload
//  line_in    in   valid/ready         word0..word7, 64 bits each
//  est_out    out  valid/ready         flits_saved, chose_zero, delta_saved, zero_saved
//  cfg        in   cfg_we (no ready)   cfg_wdata: policy, 2 bits
//
// An accepted item passes through the stage 1, stage 2 and stage 3 registers in turn before it leaves.
// One item per cycle sustained while est_out.ready is high.
// Stage 1 does the byte compares and the per-word nonzero byte counts, stage 2 the match and nonzero counts,
// stage 3 the ratios, the zero-content formula and the policy choice.
// Each stage holds its item while the next one is full and stalled.
// Reset clears the stage valid bits and sets the policy to delta only.
`default_nettype none
`include "assert_macros.svh"

module line_compressibility_estimator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    lce_line_if.sink        line_in,
    lce_est_if.source       est_out
);

    localparam int NW = lce_pkg::LINE_WORDS;
    localparam int NB = lce_pkg::WORD_BYTES;

    lce_pkg::policy_t policy_reg;

    // Stage 1 registers
    logic                s1_valid_reg;
    logic [NW-2:0]       s1_m2_reg;
    logic [NW-2:0]       s1_m4_reg;
    logic [NW-2:0]       s1_m6_reg;
    lce_pkg::byte_cnt_t  s1_nz_reg [NW];
    logic [NW-2:0]       s1_m2_next;
    logic [NW-2:0]       s1_m4_next;
    logic [NW-2:0]       s1_m6_next;
    lce_pkg::byte_cnt_t  s1_nz_next [NW];

    // Stage 2 registers
    logic                s2_valid_reg;
    logic [2:0]          s2_c2_reg;
    logic [2:0]          s2_c4_reg;
    logic [2:0]          s2_c6_reg;
    lce_pkg::line_cnt_t  s2_nz_reg;
    logic [2:0]          s2_c2_next;
    logic [2:0]          s2_c4_next;
    logic [2:0]          s2_c6_next;
    lce_pkg::line_cnt_t  s2_nz_next;

    // Stage 3 (output) registers
    logic                s3_valid_reg;
    lce_pkg::flits_t     s3_flits_reg;
    logic                s3_chose_reg;
    lce_pkg::delta_t     s3_delta_reg;
    lce_pkg::flits_t     s3_zero_reg;
    lce_pkg::flits_t     s3_flits_next;
    logic                s3_chose_next;
    lce_pkg::delta_t     s3_delta_next;
    lce_pkg::flits_t     s3_zero_next;

    logic                s1_ready;
    logic                s2_ready;
    logic                s3_ready;
    lce_pkg::word_t      words [NW];

    // Advance a stage when it is empty or the next stage takes its item
    assign s3_ready      = !s3_valid_reg || est_out.ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign line_in.ready = s1_ready;

    // Hold the policy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= lce_pkg::POLICY_DELTA;
        end
        else if (cfg_we)
        begin
            policy_reg <= lce_pkg::policy_t'(cfg_wdata);
        end
    end

    // Gather the line words
    always_comb
    begin
        words[0] = line_in.word0;
        words[1] = line_in.word1;
        words[2] = line_in.word2;
        words[3] = line_in.word3;
        words[4] = line_in.word4;
        words[5] = line_in.word5;
        words[6] = line_in.word6;
        words[7] = line_in.word7;
    end

    // Stage 1: compare upper bytes with the base and count nonzero bytes per word
    always_comb
    begin
        for (int k = 1; k < NW; k++)
        begin
            s1_m2_next[k-1] = (words[k][63:16] == words[0][63:16]);
            s1_m4_next[k-1] = (words[k][63:32] == words[0][63:32]);
            s1_m6_next[k-1] = (words[k][63:48] == words[0][63:48]);
        end
        for (int k = 0; k < NW; k++)
        begin
            s1_nz_next[k] = '0;
            for (int j = 0; j < NB; j++)
            begin
                s1_nz_next[k] = s1_nz_next[k]
                    + lce_pkg::byte_cnt_t'(words[k][8*j +: 8] != 8'h00);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= line_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && line_in.valid)
        begin
            s1_m2_reg <= s1_m2_next;
            s1_m4_reg <= s1_m4_next;
            s1_m6_reg <= s1_m6_next;
            s1_nz_reg <= s1_nz_next;
        end
    end

    // Stage 2: count matching words and nonzero bytes of the line
    always_comb
    begin
        s2_c2_next = '0;
        s2_c4_next = '0;
        s2_c6_next = '0;
        for (int k = 0; k < NW-1; k++)
        begin
            s2_c2_next = s2_c2_next + 3'(s1_m2_reg[k]);
            s2_c4_next = s2_c4_next + 3'(s1_m4_reg[k]);
            s2_c6_next = s2_c6_next + 3'(s1_m6_reg[k]);
        end
        s2_nz_next = '0;
        for (int k = 0; k < NW; k++)
        begin
            s2_nz_next = s2_nz_next + lce_pkg::line_cnt_t'(s1_nz_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_c2_reg <= s2_c2_next;
            s2_c4_reg <= s2_c4_next;
            s2_c6_reg <= s2_c6_next;
            s2_nz_reg <= s2_nz_next;
        end
    end

    // Stage 3: ratios, zero-content estimate and policy choice
    logic [5:0] s3_c2x6;
    logic [2:0] s3_s75;
    logic [2:0] s3_s50;
    logic [2:0] s3_s25;
    logic [9:0] s3_nz7;
    logic [5:0] s3_saved_bytes;
    logic       s3_delta_wins;

    always_comb
    begin
        // (c*6)/8, (c*4)/8 and (c*2)/8, truncated
        s3_c2x6 = {1'b0, s2_c2_reg, 2'b00} + {2'b00, s2_c2_reg, 1'b0};
        s3_s75  = s3_c2x6[5:3];
        s3_s50  = {1'b0, s2_c4_reg[2:1]};
        s3_s25  = {2'b00, s2_c6_reg[2]};
        s3_delta_next = s3_s25;
        if (s3_s50 > s3_delta_next)
        begin
            s3_delta_next = s3_s50;
        end
        if (s3_s75 > s3_delta_next)
        begin
            s3_delta_next = s3_s75;
        end

        // Bits = 64 + 7 * nonzero, so saved bytes = 56 - (7 * nonzero) / 8
        s3_nz7         = {s2_nz_reg, 3'b000} - {3'b000, s2_nz_reg};
        s3_saved_bytes = 6'd56 - s3_nz7[8:3];
        s3_zero_next   = $signed({1'b0, s3_saved_bytes[5:3]}) - 4'sd1;

        s3_delta_wins = $signed({1'b0, s3_delta_next}) > s3_zero_next;

        unique case (policy_reg)
            lce_pkg::POLICY_DELTA:
            begin
                s3_flits_next = $signed({1'b0, s3_delta_next});
                s3_chose_next = 1'b0;
            end
            lce_pkg::POLICY_ZERO:
            begin
                s3_flits_next = s3_zero_next;
                s3_chose_next = 1'b1;
            end
            default:
            begin
                s3_flits_next = s3_delta_wins ? $signed({1'b0, s3_delta_next})
                                              : s3_zero_next;
                s3_chose_next = !s3_delta_wins;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_flits_reg <= s3_flits_next;
            s3_chose_reg <= s3_chose_next;
            s3_delta_reg <= s3_delta_next;
            s3_zero_reg  <= s3_zero_next;
        end
    end

    // Drive the result channel
    assign est_out.valid       = s3_valid_reg;
    assign est_out.flits_saved = s3_flits_reg;
    assign est_out.chose_zero  = s3_chose_reg;
    assign est_out.delta_saved = s3_delta_reg;
    assign est_out.zero_saved  = s3_zero_reg;

    // Checks on the pipeline and the reported result
    `LCE_ASSERT(a_s2_fill, (s1_valid_reg && s2_ready) |=> s2_valid_reg, "stage 2 lost an item")
    `LCE_ASSERT(a_out_fill, (s2_valid_reg && s3_ready) |=> s3_valid_reg, "output lost an item")
    `LCE_ASSERT(a_delta_pick, (est_out.valid && !est_out.chose_zero) |-> (est_out.flits_saved == $signed({1'b0, est_out.delta_saved})), "delta result mismatch")
    `LCE_ASSERT(a_zero_pick, (est_out.valid && est_out.chose_zero) |-> (est_out.flits_saved == est_out.zero_saved), "zero-content result mismatch")
    `LCE_NEVER(a_delta_range, est_out.valid && (est_out.delta_saved > 3'd5), "delta estimate out of range")

endmodule

`default_nettype wire
